// ----- rtl/rxc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package rxc_pkg;

	localparam int unsigned MaxStrideDef  = 4096;
	localparam int unsigned MaxRecordsDef = 1024;

	localparam int unsigned COL_W  = 23;
	localparam int unsigned ROW_W  = 21;
	localparam int unsigned RWID_W = 23;
	localparam int unsigned RTOT_W = 35;
	localparam int unsigned PROD_W = 36;

	localparam logic [63:0] STRIDE_LIMIT = 64'd4 << 20;
	localparam logic [63:0] MATRIX_LIMIT = 64'd1 << 34;
	localparam logic [7:0]  VERSION_ONE  = 8'h01;

	typedef enum logic [3:0] {
		PH_MAGIC, PH_VERSION, PH_LEN, PH_COUNT, PH_STRIDE,
		PH_RECLEN, PH_MATLEN, PH_MATRIX, PH_DONE
	} phase_t;

	typedef enum logic [3:0] {
		ERR_NONE, ERR_MAGIC, ERR_VERSION, ERR_VTRUNC, ERR_VOVER, ERR_COUNT,
		ERR_STRIDE, ERR_MBOUND, ERR_LEN, ERR_SUMOVER, ERR_SUMNE, ERR_NOTMAX,
		ERR_MATLEN, ERR_MTRUNC, ERR_TRAIL, ERR_CAP
	} err_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_final;
	} in_word_t;

	typedef struct packed {
		logic       out_valid;
		logic [7:0] out_byte;
		logic [3:0] error_code;
		logic       carrier_done;
	} out_word_t;

	typedef struct packed {
		logic             mat;
		logic             first;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic [7:0]       mbyte;
		logic             len_we;
		logic [COL_W-1:0] len_data;
		err_t             err;
		logic             done;
	} cmd_t;

	function automatic logic [7:0] magic_byte(input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0: b = 8'h47;
			2'd1: b = 8'h30;
			2'd2: b = 8'h56;
			default: b = 8'h58;
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/rxc_chan.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface rxc_chan #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/rxc_parse.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rxc_parse #(
	parameter int unsigned MAX_STRIDE  = rxc_pkg::MaxStrideDef,
	parameter int unsigned MAX_RECORDS = rxc_pkg::MaxRecordsDef
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          acc,
	input  wire logic [7:0]    in_byte,
	input  wire logic          in_final,
	output rxc_pkg::cmd_t      cmd
);
	localparam int unsigned CW = $clog2(MAX_STRIDE + 1);
	localparam int unsigned RW = $clog2(MAX_RECORDS + 1);

	rxc_pkg::phase_t               phase_q, phase_n;
	rxc_pkg::err_t                 err_q, e;
	logic [1:0]                    hpos_q, hpos_n;
	logic [63:0]                   vval_q, vval_n;
	logic [3:0]                    vpos_q, vpos_n;
	logic [63:0]                   dlen_q, dlen_n;
	logic [rxc_pkg::RTOT_W-1:0]    rtot_q, rtot_n;
	logic [rxc_pkg::RWID_W-1:0]    rwid_q, rwid_n;
	logic [63:0]                   lsum_q, lsum_n;
	logic [rxc_pkg::RWID_W-1:0]    llong_q, llong_n;
	logic [rxc_pkg::PROD_W-1:0]    prod_q, prod_n;
	logic [RW-1:0]                 row_q, row_n;
	logic [CW-1:0]                 col_q, col_n;

	logic [5:0]                    sh;
	logic [63:0]                   v;
	logic                          vover;
	logic [105:0]                  term;
	logic [rxc_pkg::PROD_W:0]      psum;
	logic [rxc_pkg::PROD_W-1:0]    padd;
	logic [63:0]                   diff;

	always_comb begin
		sh    = 6'(7'(vpos_q) * 7'd7);
		v     = vval_q | (64'(in_byte[6:0]) << sh);
		vover = (vpos_q == 4'd9) && (in_byte[7:1] != 7'd0);
		term  = 106'(42'(rtot_q) * 42'(in_byte[6:0])) << sh;
		psum  = 37'(prod_q) + 37'(term[rxc_pkg::PROD_W-1:0]);
		padd  = (term[105:rxc_pkg::PROD_W] != '0 || psum[rxc_pkg::PROD_W]) ? '1
			: psum[rxc_pkg::PROD_W-1:0];
		diff  = dlen_q - lsum_q;
	end

	always_comb begin
		phase_n = phase_q;
		e       = err_q;
		hpos_n  = hpos_q;
		vval_n  = vval_q;
		vpos_n  = vpos_q;
		dlen_n  = dlen_q;
		rtot_n  = rtot_q;
		rwid_n  = rwid_q;
		lsum_n  = lsum_q;
		llong_n = llong_q;
		prod_n  = prod_q;
		row_n   = row_q;
		col_n   = col_q;
		cmd     = '0;
		if (err_q == rxc_pkg::ERR_NONE) begin
			case (phase_q)
				rxc_pkg::PH_MAGIC: begin
					if (in_byte != rxc_pkg::magic_byte(hpos_q)) begin
						e = rxc_pkg::ERR_MAGIC;
					end else begin
						hpos_n = hpos_q + 2'd1;
						if (hpos_q == 2'd3) begin
							phase_n = rxc_pkg::PH_VERSION;
						end
					end
				end
				rxc_pkg::PH_VERSION: begin
					if (in_byte != rxc_pkg::VERSION_ONE) begin
						e = rxc_pkg::ERR_VERSION;
					end else begin
						phase_n = rxc_pkg::PH_LEN;
					end
				end
				rxc_pkg::PH_LEN, rxc_pkg::PH_COUNT, rxc_pkg::PH_STRIDE,
				rxc_pkg::PH_RECLEN, rxc_pkg::PH_MATLEN: begin
					if (vover) begin
						e = rxc_pkg::ERR_VOVER;
					end else if (in_byte[7]) begin
						vval_n = v;
						vpos_n = vpos_q + 4'd1;
						if (phase_q == rxc_pkg::PH_STRIDE) begin
							prod_n = padd;
						end
					end else begin
						vval_n = '0;
						vpos_n = '0;
						case (phase_q)
							rxc_pkg::PH_LEN: begin
								dlen_n  = v;
								phase_n = rxc_pkg::PH_COUNT;
							end
							rxc_pkg::PH_COUNT: begin
								rtot_n  = (v[63:rxc_pkg::RTOT_W] != '0) ? '1
									: v[rxc_pkg::RTOT_W-1:0];
								prod_n  = '0;
								phase_n = rxc_pkg::PH_STRIDE;
							end
							rxc_pkg::PH_STRIDE: begin
								rwid_n = v[rxc_pkg::RWID_W-1:0];
								prod_n = padd;
								if (rtot_q < 35'd8) begin
									e = rxc_pkg::ERR_COUNT;
								end else if (v > rxc_pkg::STRIDE_LIMIT) begin
									e = rxc_pkg::ERR_STRIDE;
								end else if (v != 64'd0 && 64'(padd) > rxc_pkg::MATRIX_LIMIT) begin
									e = rxc_pkg::ERR_MBOUND;
								end else if (rtot_q > 35'(MAX_RECORDS)
									|| v > 64'(MAX_STRIDE)) begin
									e = rxc_pkg::ERR_CAP;
								end else begin
									row_n   = '0;
									phase_n = rxc_pkg::PH_RECLEN;
								end
							end
							rxc_pkg::PH_RECLEN: begin
								if (v > 64'(rwid_q)) begin
									e = rxc_pkg::ERR_LEN;
								end else if (v > diff) begin
									e = rxc_pkg::ERR_SUMOVER;
								end else begin
									lsum_n       = lsum_q + v;
									llong_n      = (v[rxc_pkg::RWID_W-1:0] > llong_q)
										? v[rxc_pkg::RWID_W-1:0] : llong_q;
									cmd.len_we   = 1'b1;
									cmd.row      = rxc_pkg::ROW_W'(row_q);
									cmd.len_data = rxc_pkg::COL_W'(v[rxc_pkg::RWID_W-1:0]);
									row_n        = row_q + RW'(1);
									if (35'(row_q) + 35'd1 >= rtot_q) begin
										if (v != diff) begin
											e = rxc_pkg::ERR_SUMNE;
										end else if (llong_n != rwid_q) begin
											e = rxc_pkg::ERR_NOTMAX;
										end else begin
											phase_n = rxc_pkg::PH_MATLEN;
										end
									end
								end
							end
							default: begin
								if (v != 64'(prod_q)) begin
									e = rxc_pkg::ERR_MATLEN;
								end else begin
									row_n   = '0;
									col_n   = '0;
									phase_n = (v == 64'd0) ? rxc_pkg::PH_DONE
										: rxc_pkg::PH_MATRIX;
								end
							end
						endcase
					end
				end
				rxc_pkg::PH_MATRIX: begin
					cmd.mat   = 1'b1;
					cmd.first = (row_q == '0);
					cmd.col   = rxc_pkg::COL_W'(col_q);
					cmd.row   = rxc_pkg::ROW_W'(row_q);
					cmd.mbyte = in_byte;
					col_n     = col_q + CW'(1);
					if (rxc_pkg::RWID_W'(col_q) + 23'd1 >= rwid_q) begin
						col_n = '0;
						row_n = row_q + RW'(1);
						if (35'(row_q) + 35'd1 >= rtot_q) begin
							phase_n = rxc_pkg::PH_DONE;
						end
					end
				end
				rxc_pkg::PH_DONE: begin
					e = rxc_pkg::ERR_TRAIL;
				end
				default: begin
					e = err_q;
				end
			endcase
		end
		if (in_final && e == rxc_pkg::ERR_NONE && phase_n != rxc_pkg::PH_DONE) begin
			if (phase_n == rxc_pkg::PH_MAGIC) begin
				e = rxc_pkg::ERR_MAGIC;
			end else if (phase_n == rxc_pkg::PH_MATRIX) begin
				e = rxc_pkg::ERR_MTRUNC;
			end else begin
				e = rxc_pkg::ERR_VTRUNC;
			end
		end
		cmd.err  = e;
		cmd.done = in_final;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= rxc_pkg::PH_MAGIC;
			err_q   <= rxc_pkg::ERR_NONE;
			hpos_q  <= '0;
			vval_q  <= '0;
			vpos_q  <= '0;
			dlen_q  <= '0;
			rtot_q  <= '0;
			rwid_q  <= '0;
			lsum_q  <= '0;
			llong_q <= '0;
			prod_q  <= '0;
			row_q   <= '0;
			col_q   <= '0;
		end else if (acc) begin
			if (in_final) begin
				phase_q <= rxc_pkg::PH_MAGIC;
				err_q   <= rxc_pkg::ERR_NONE;
				hpos_q  <= '0;
				vval_q  <= '0;
				vpos_q  <= '0;
				dlen_q  <= '0;
				rtot_q  <= '0;
				rwid_q  <= '0;
				lsum_q  <= '0;
				llong_q <= '0;
				prod_q  <= '0;
				row_q   <= '0;
				col_q   <= '0;
			end else begin
				phase_q <= phase_n;
				err_q   <= e;
				hpos_q  <= hpos_n;
				vval_q  <= vval_n;
				vpos_q  <= vpos_n;
				dlen_q  <= dlen_n;
				rtot_q  <= rtot_n;
				rwid_q  <= rwid_n;
				lsum_q  <= lsum_n;
				llong_q <= llong_n;
				prod_q  <= prod_n;
				row_q   <= row_n;
				col_q   <= col_n;
			end
		end
	end
endmodule
`default_nettype wire

// ----- rtl/rxc_rows.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rxc_rows #(
	parameter int unsigned MAX_STRIDE  = rxc_pkg::MaxStrideDef,
	parameter int unsigned MAX_RECORDS = rxc_pkg::MaxRecordsDef
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          acc,
	input  wire rxc_pkg::cmd_t cmd,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	output rxc_pkg::out_word_t out_word
);
	localparam int unsigned AW = (MAX_STRIDE > 1) ? $clog2(MAX_STRIDE) : 1;
	localparam int unsigned LW = $clog2(MAX_STRIDE + 1);
	localparam int unsigned RA = $clog2(MAX_RECORDS);

	logic [7:0]    line_mem [MAX_STRIDE];
	logic [LW-1:0] len_mem  [MAX_RECORDS];

	logic          v_s1;
	logic          mat_s1, first_s1, fwd_s1, done_s1;
	logic [AW-1:0] col_s1;
	logic [7:0]    byte_s1, rd_s1;
	logic [LW-1:0] len_s1;
	logic [3:0]    err_s1;
	logic [7:0]    last_q;
	logic [7:0]    cur;
	logic          adv, out_free;
	rxc_pkg::out_word_t res;

	assign out_free = !out_valid || out_ready;
	assign adv      = v_s1 && out_free;
	assign in_ready = !v_s1 || out_free;

	always_comb begin
		cur = first_s1 ? byte_s1 : (byte_s1 ^ (fwd_s1 ? last_q : rd_s1));
		res.out_valid    = mat_s1 && (LW'(col_s1) < len_s1);
		res.out_byte     = res.out_valid ? cur : 8'd0;
		res.error_code   = err_s1;
		res.carrier_done = done_s1;
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rd_s1 <= line_mem[cmd.col[AW-1:0]];
			len_s1 <= len_mem[cmd.row[RA-1:0]];
		end
		if (adv && mat_s1) begin
			line_mem[col_s1] <= cur;
		end
		if (acc && cmd.len_we) begin
			len_mem[cmd.row[RA-1:0]] <= cmd.len_data[LW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			mat_s1   <= cmd.mat;
			first_s1 <= cmd.first;
			col_s1   <= cmd.col[AW-1:0];
			byte_s1  <= cmd.mbyte;
			err_s1   <= cmd.err;
			done_s1  <= cmd.done;
			fwd_s1   <= v_s1 && mat_s1 && (col_s1 == cmd.col[AW-1:0]);
		end
		if (adv && mat_s1) begin
			last_q <= cur;
		end
		if (adv) begin
			out_word <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (acc) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

// ----- rtl/row_xor_carrier_decoder.sv -----
// Row-XOR carrier decoder. Takes one carrier word per cycle on in_ch while out_ch is ready
// and returns one result word per carrier word on out_ch; each result passes through the s1
// registers and then the result register. The header, varint fields and every format rule
// are checked in the parser as each word arrives; matrix words go through a registered
// line-store read, an XOR with the row above (forwarded when the stride is one) and the
// result register. The line store holds MAX_STRIDE bytes and the length store MAX_RECORDS
// lengths; larger carriers report a capacity error. Errors stick until the word marked
// final, after which the block rearms. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none
module row_xor_carrier_decoder #(
	parameter int unsigned MAX_STRIDE  = rxc_pkg::MaxStrideDef,
	parameter int unsigned MAX_RECORDS = rxc_pkg::MaxRecordsDef
) (
	input wire logic clk,
	input wire logic arst_n,
	rxc_chan.sink    in_ch,
	rxc_chan.source  out_ch
);
	rxc_pkg::cmd_t      cmd;
	rxc_pkg::in_word_t  in_word;
	rxc_pkg::out_word_t out_word;
	logic               acc;
	logic               in_ready;

	assign in_word     = in_ch.data;
	assign in_ch.ready = in_ready;
	assign acc         = in_ch.valid && in_ready;
	assign out_ch.data = out_word;

	rxc_parse #(.MAX_STRIDE(MAX_STRIDE), .MAX_RECORDS(MAX_RECORDS)) u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (acc),
		.in_byte  (in_word.in_byte),
		.in_final (in_word.in_final),
		.cmd      (cmd)
	);

	rxc_rows #(.MAX_STRIDE(MAX_STRIDE), .MAX_RECORDS(MAX_RECORDS)) u_rows (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.cmd       (cmd),
		.in_ready  (in_ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_word  (out_word)
	);
endmodule
`default_nettype wire

// ----- rtl/rxc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rxc_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire rxc_pkg::out_word_t out_word
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word))
		else $error("result word dropped or changed while stalled");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_word.out_valid |-> out_word.out_byte == 8'd0)
		else $error("non-data result carries a byte");

	a_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.out_valid |->
			(out_word.error_code == rxc_pkg::ERR_NONE
			|| out_word.error_code == rxc_pkg::ERR_MTRUNC))
		else $error("data byte emitted with an error pending");
endmodule

bind row_xor_carrier_decoder rxc_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_word  (out_ch.data)
);
`default_nettype wire

// ----- sim/row_xor_carrier_decoder_checker.sv -----
`timescale 1ns / 1ps
module row_xor_carrier_decoder_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input rxc_pkg::in_word_t in_data,
	input wire logic out_valid,
	input wire logic out_ready,
	input rxc_pkg::out_word_t out_data,
	output int fail_count,
	output int pending
);
	rxc_pkg::phase_t    ph;
	logic [2:0]         hdr_pos;
	logic [63:0]        vint;
	logic [3:0]         vpos;
	logic [63:0]        dec_len;
	logic [63:0]        rec_total;
	logic [63:0]        stride;
	logic [63:0]        len_sum;
	logic [63:0]        longest;
	logic [63:0]        rec_len [rxc_pkg::MaxRecordsDef];
	logic [63:0]        row;
	logic [63:0]        col;
	logic [7:0]         prev_row [rxc_pkg::MaxStrideDef];
	rxc_pkg::err_t      err;
	rxc_pkg::out_word_t expected_words [$];

	function automatic logic [7:0] magic_at(input logic [2:0] i);
		logic [7:0] m;
		case (i)
			3'd0: m = "G";
			3'd1: m = "0";
			3'd2: m = "V";
			default: m = "X";
		endcase
		return m;
	endfunction

	task automatic rearm();
		ph = rxc_pkg::PH_MAGIC;
		hdr_pos = 0;
		vint = 0;
		vpos = 0;
		dec_len = 0;
		rec_total = 0;
		stride = 0;
		len_sum = 0;
		longest = 0;
		row = 0;
		col = 0;
		err = rxc_pkg::ERR_NONE;
	endtask

	task automatic decode_word(input rxc_pkg::in_word_t w);
		rxc_pkg::out_word_t o;
		logic [7:0] b;
		logic [7:0] cur;
		logic [63:0] v;
		int r;
		o = '0;
		b = w.in_byte;
		if (err == rxc_pkg::ERR_NONE) begin
			if (ph == rxc_pkg::PH_MAGIC) begin
				if (hdr_pos > 3 || b != magic_at(hdr_pos)) err = rxc_pkg::ERR_MAGIC;
				else begin
					hdr_pos++;
					if (hdr_pos == 4) ph = rxc_pkg::PH_VERSION;
				end
			end else if (ph == rxc_pkg::PH_VERSION) begin
				if (b != 8'd1) err = rxc_pkg::ERR_VERSION;
				else ph = rxc_pkg::PH_LEN;
			end else if (ph >= rxc_pkg::PH_LEN && ph <= rxc_pkg::PH_MATLEN) begin
				r = 0;
				if (vpos >= 10 || (vpos == 9 && (b & 8'hfe) != 0)) r = -1;
				else begin
					vint |= 64'(b[6:0]) << (7 * vpos);
					vpos++;
					if (!b[7]) r = 1;
				end
				if (r < 0) err = rxc_pkg::ERR_VOVER;
				else if (r > 0) begin
					v = vint;
					vint = 0;
					vpos = 0;
					case (ph)
						rxc_pkg::PH_LEN: begin
							dec_len = v;
							ph = rxc_pkg::PH_COUNT;
						end
						rxc_pkg::PH_COUNT: begin
							rec_total = v;
							ph = rxc_pkg::PH_STRIDE;
						end
						rxc_pkg::PH_STRIDE: begin
							stride = v;
							if (rec_total < 8) err = rxc_pkg::ERR_COUNT;
							else if (v > rxc_pkg::STRIDE_LIMIT) err = rxc_pkg::ERR_STRIDE;
							else if (v != 0 && rec_total > rxc_pkg::MATRIX_LIMIT / v)
								err = rxc_pkg::ERR_MBOUND;
							else if (rec_total > rxc_pkg::MaxRecordsDef
								|| v > rxc_pkg::MaxStrideDef)
								err = rxc_pkg::ERR_CAP;
							else begin
								row = 0;
								ph = rxc_pkg::PH_RECLEN;
							end
						end
						rxc_pkg::PH_RECLEN: begin
							if (v > stride) err = rxc_pkg::ERR_LEN;
							else if (len_sum > dec_len || v > dec_len - len_sum)
								err = rxc_pkg::ERR_SUMOVER;
							else begin
								len_sum += v;
								if (v > longest) longest = v;
								if (row < rxc_pkg::MaxRecordsDef) rec_len[row] = v;
								row++;
								if (row >= rec_total) begin
									if (len_sum != dec_len) err = rxc_pkg::ERR_SUMNE;
									else if (longest != stride) err = rxc_pkg::ERR_NOTMAX;
									else ph = rxc_pkg::PH_MATLEN;
								end
							end
						end
						default: begin
							if (v != rec_total * stride) err = rxc_pkg::ERR_MATLEN;
							else begin
								row = 0;
								col = 0;
								ph = (v == 0) ? rxc_pkg::PH_DONE : rxc_pkg::PH_MATRIX;
							end
						end
					endcase
				end
			end else if (ph == rxc_pkg::PH_MATRIX) begin
				cur = b;
				if (col < rxc_pkg::MaxStrideDef) begin
					if (row != 0) cur = b ^ prev_row[col];
					prev_row[col] = cur;
				end
				if (row < rxc_pkg::MaxRecordsDef && col < rec_len[row]) begin
					o.out_valid = 1'b1;
					o.out_byte = cur;
				end
				col++;
				if (col >= stride) begin
					col = 0;
					row++;
					if (row >= rec_total) ph = rxc_pkg::PH_DONE;
				end
			end else err = rxc_pkg::ERR_TRAIL;
		end
		if (w.in_final && err == rxc_pkg::ERR_NONE && ph != rxc_pkg::PH_DONE) begin
			if (ph == rxc_pkg::PH_MAGIC) err = rxc_pkg::ERR_MAGIC;
			else if (ph == rxc_pkg::PH_MATRIX) err = rxc_pkg::ERR_MTRUNC;
			else err = rxc_pkg::ERR_VTRUNC;
		end
		o.error_code = err;
		o.carrier_done = w.in_final;
		expected_words = {expected_words, o};
		if (w.in_final) rearm();
	endtask

	always @(posedge clk) begin
		rxc_pkg::out_word_t e;
		if (!arst_n) begin
			rearm();
			expected_words.delete();
		end else begin
			if (in_valid && in_ready) decode_word(in_data);
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					$error("unexpected word %h", out_data);
					fail_count++;
				end else begin
					e = expected_words.pop_front();
					if (e.out_valid != out_data.out_valid) begin
						$error("out_valid exp %0d got %0d", e.out_valid, out_data.out_valid);
						fail_count++;
					end
					if (e.out_byte != out_data.out_byte) begin
						$error("out_byte exp %h got %h", e.out_byte, out_data.out_byte);
						fail_count++;
					end
					if (e.error_code != out_data.error_code) begin
						$error("error_code exp %0d got %0d", e.error_code, out_data.error_code);
						fail_count++;
					end
					if (e.carrier_done != out_data.carrier_done) begin
						$error("carrier_done exp %0d got %0d", e.carrier_done,
							out_data.carrier_done);
						fail_count++;
					end
				end
			end
		end
		pending <= expected_words.size();
	end
endmodule

// ----- sim/row_xor_carrier_decoder_tb.sv -----
`timescale 1ns / 1ps
module row_xor_carrier_decoder_tb;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count;
	int   pending;
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	int   hold_cycles;
	logic hold_req = 1'b0;
	logic hold_taken;
	int   sent = 0;
	logic [7:0] word_bytes [$];
	logic       word_finals [$];

	rxc_chan #(.T(rxc_pkg::in_word_t)) in_ch ();
	rxc_chan #(.T(rxc_pkg::out_word_t)) out_ch ();

	row_xor_carrier_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	row_xor_carrier_decoder_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.in_data(in_ch.data),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.out_data(out_ch.data),
		.fail_count(fail_count),
		.pending(pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			hold_cycles <= 0;
			hold_taken <= 1'b0;
			out_ch.ready <= 1'b0;
		end else if (hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_cycles <= 300;
			out_ch.ready <= 1'b0;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ch.ready <= 1'b0;
		end else out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic put_varint(input logic [63:0] v);
		do begin
			word_bytes = {word_bytes, {v > 127 ? 1'b1 : 1'b0, v[6:0]}};
			word_finals = {word_finals, 1'b0};
			v = v >> 7;
		end while (v != 0);
	endtask

	task automatic put_byte(input logic [7:0] b);
		word_bytes = {word_bytes, b};
		word_finals = {word_finals, 1'b0};
	endtask

	// build a carrier; corrupt chooses one fault to inject, 0 for none
	task automatic build_carrier(input int cnt, input int strd, input int corrupt);
		int lens [$];
		int sum;
		int k;
		sum = 0;
		for (int i = 0; i < cnt; i++) begin
			lens = {lens, int'($urandom_range(strd))};
		end
		if (cnt > 0) lens[$urandom_range(cnt - 1)] = strd;
		foreach (lens[i]) sum += lens[i];
		put_byte(corrupt == 1 ? 8'h47 ^ 8'($urandom_range(1, 255)) : 8'h47);
		put_byte(8'h30);
		put_byte(8'h56);
		put_byte(8'h58);
		put_byte(corrupt == 2 ? 8'($urandom_range(2, 255)) : 8'h01);
		put_varint(corrupt == 3 ? sum + 1 : sum);
		put_varint(cnt);
		put_varint(strd);
		foreach (lens[i]) put_varint(lens[i]);
		put_varint(corrupt == 4 ? cnt * strd + 1 : cnt * strd);
		k = (corrupt == 5) ? cnt * strd - 1 - $urandom_range(cnt * strd - 1) : cnt * strd;
		for (int i = 0; i < k; i++) put_byte(8'($urandom));
		if (corrupt == 6) put_byte(8'($urandom));
		word_finals[$] = 1'b1;
	endtask

	task automatic build_raw(input logic [7:0] bytes [$]);
		foreach (bytes[i]) put_byte(bytes[i]);
		word_finals[$] = 1'b1;
	endtask

	task automatic send_all();
		while (word_bytes.size() > 0) begin
			if ($urandom_range(99) < send_idle_pct) begin
				in_ch.valid <= 1'b0;
				@(posedge clk);
			end else begin
				in_ch.valid <= 1'b1;
				in_ch.data <= {word_bytes.pop_front(), word_finals.pop_front()};
				sent++;
				do @(posedge clk); while (!in_ch.ready);
			end
		end
		in_ch.valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending != 0) @(posedge clk);
	endtask

	task automatic random_carrier();
		int pick;
		pick = $urandom_range(99);
		if (pick < 75) build_carrier($urandom_range(8, 12), $urandom_range(1, 8), 0);
		else if (pick < 90) build_carrier($urandom_range(8, 10), $urandom_range(1, 6),
			$urandom_range(1, 6));
		else begin
			for (int i = 0; i < $urandom_range(1, 12); i++) put_byte(8'($urandom));
			word_finals[$] = 1'b1;
		end
	endtask

	initial begin
		in_ch.valid <= 1'b0;
		in_ch.data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		build_carrier(8, 1, 0);
		build_carrier(8, 0, 0);
		build_carrier(9, 4, 6);
		build_carrier(8, 3, 5);
		build_raw('{8'h47, 8'h30});
		build_raw('{8'h47, 8'h30, 8'h56, 8'h58, 8'h01, 8'h85});
		build_raw('{8'h47, 8'h30, 8'h56, 8'h58, 8'h01, 8'h00, 8'h07, 8'h01});
		build_raw('{8'h47, 8'h30, 8'h56, 8'h58, 8'h01, 8'h00, 8'h08, 8'h80, 8'h80, 8'h80,
			8'h02});
		build_raw('{8'h47, 8'h30, 8'h56, 8'h58, 8'h01, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff,
			8'h01, 8'h01});
		build_raw('{8'h47, 8'h30, 8'h56, 8'h58, 8'h01, 8'h00, 8'h81, 8'h08, 8'h01});
		build_raw('{8'h47, 8'h30, 8'h56, 8'h58, 8'h01, 8'h00, 8'h08, 8'h81, 8'h20});
		build_raw('{8'h47, 8'h30, 8'h56, 8'h58, 8'h01, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
			8'hff, 8'hff, 8'hff, 8'hff, 8'h02});
		build_raw('{8'h47, 8'h30, 8'h56, 8'h58, 8'h01, 8'h05, 8'h08, 8'h02, 8'h03});
		build_raw('{8'h47, 8'h30, 8'h56, 8'h58, 8'h01, 8'h01, 8'h08, 8'h02, 8'h01, 8'h01});
		build_raw('{8'h47, 8'h30, 8'h56, 8'h58, 8'h01, 8'h00, 8'h08, 8'h02, 8'h00, 8'h00,
			8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
		send_all();
		drain();
		// several idling profiles over the random carriers
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = (p == 1 || p == 3) ? ((p == 1) ? 67 : 14) : 0;
			recv_stall_pct = (p == 2) ? 67 : ((p == 3) ? 14 : 0);
			if (p == 2) hold_req = 1'b1;
			while (sent < 240 + p * 200) begin
				random_carrier();
				send_all();
			end
			drain();
		end
		repeat (20) @(posedge clk);
		if (fail_count == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end

	initial begin
		#400000;
		$display("Some tests failed");
		$finish;
	end
endmodule

// ----- sim.f -----
rtl/rxc_pkg.sv
rtl/rxc_chan.sv
rtl/rxc_parse.sv
rtl/rxc_rows.sv
rtl/row_xor_carrier_decoder.sv
rtl/rxc_checker.sv
sim/row_xor_carrier_decoder_checker.sv
sim/row_xor_carrier_decoder_tb.sv
